>>> design/ssrt_pkg.sv
// Shared types and constants for the sorted schedule record table.
// Holds the beat payloads, operation and status codes and the cell control types.
// No dependencies.
`default_nettype none

package ssrt_pkg;

  // Default table depth; the top level parameter overrides it
  localparam int unsigned MAX_RECORDS_DEF = 32;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 11;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_FIND = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  // Command beat
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  minute_key;
    logic              on_state;
    logic [SLOT_W-1:0] slot_index;
  } cmd_t;

  // Response beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    result_key;
    logic                result_state;
    logic [TOTAL_W-1:0]  record_total;
  } rsp_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              cmp_en;     // compare step: capture flags
    logic              pick_en;    // find or read: raise pick flag
    logic              is_read;    // pick by position rather than by key
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic              new_state;
    logic              apply_ins;  // insert new record, shift up
    logic              apply_upd;  // overwrite state of matching record
    logic              apply_del;  // remove matching record, shift down
  } cell_ctrl_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             state;
    logic             lt;          // occupied and key below the command key
  } cell_link_t;

endpackage

`default_nettype wire

>>> design/ssrt_chan_if.sv
// Valid/ready channel carrying one beat of a payload type.
// Depends on nothing; payload types come from ssrt_pkg at instantiation.
`default_nettype none

interface ssrt_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/sorted_schedule_record_table.sv
// Sorted schedule record table: a row of MAX_RECORDS cells keeping records in
// ascending minute order, with add/update, delete, find and read commands.
// Each command beat is handled in a take cycle, at whose end every cell
// registers its compare flags, and an apply cycle in which the row shifts or
// updates and the response is registered. A new command is taken the cycle
// after apply at the earliest, so a beat is not taken before the last one is
// applied; a stalled response holds the apply cycle. Stored records are not
// reset and need no clearing after reset; the record count is reset.
// Depends on ssrt_pkg, ssrt_chan_if and ssrt_cell.
`default_nettype none

module sorted_schedule_record_table #(
  parameter int unsigned MAX_RECORDS = ssrt_pkg::MAX_RECORDS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ssrt_chan_if.sink    cmd_i,
  ssrt_chan_if.source  rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic                           fsm_q, fsm_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [ssrt_pkg::OP_W-1:0]      op_q;
  logic [ssrt_pkg::KEY_W-1:0]     key_q;
  logic                           state_q;
  ssrt_pkg::rsp_t                 rsp_q, rsp_d;
  logic                           rsp_valid_q, rsp_valid_d;
  logic                           take, go, full, any_hit, any_pick;
  ssrt_pkg::cell_ctrl_t           ctrl;
  ssrt_pkg::cell_link_t           link    [MAX_RECORDS];
  ssrt_pkg::cell_link_t           left_l  [MAX_RECORDS];
  ssrt_pkg::cell_link_t           right_l [MAX_RECORDS];
  logic [MAX_RECORDS-1:0]         hit_vec, pick_vec, pick_state_vec;
  logic [ssrt_pkg::KEY_W-1:0]     pick_key [MAX_RECORDS];
  logic [ssrt_pkg::KEY_W-1:0]     sel_key;
  ssrt_pkg::status_e              status;

  // Handshake and sequencing
  assign cmd_i.ready = fsm_q == S_IDLE;
  assign take        = cmd_i.valid && cmd_i.ready;
  assign go          = (fsm_q == S_APPLY) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      S_IDLE:  if (take) fsm_d = S_APPLY;
      S_APPLY: if (go) fsm_d = S_IDLE;
      default: fsm_d = S_IDLE;
    endcase
  end

  // Command capture
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q    <= cmd_i.data.operation;
      key_q   <= cmd_i.data.minute_key;
      state_q <= cmd_i.data.on_state;
    end
  end

  // Global flags from the row
  assign any_hit  = |hit_vec;
  assign any_pick = |pick_vec;
  assign full     = count_q >= CNT_W'(MAX_RECORDS);

  // Cell control broadcast
  always_comb begin
    ctrl.cmp_en    = take;
    ctrl.pick_en   = (cmd_i.data.operation == ssrt_pkg::OP_FIND) ||
                     (cmd_i.data.operation == ssrt_pkg::OP_READ);
    ctrl.is_read   = cmd_i.data.operation == ssrt_pkg::OP_READ;
    ctrl.key       = take ? cmd_i.data.minute_key : key_q;
    ctrl.slot      = cmd_i.data.slot_index;
    ctrl.new_state = state_q;
    ctrl.apply_ins = go && (op_q == ssrt_pkg::OP_ADD) && !full && !any_hit;
    ctrl.apply_upd = go && (op_q == ssrt_pkg::OP_ADD) && !full && any_hit;
    ctrl.apply_del = go && (op_q == ssrt_pkg::OP_DEL) && any_hit;
  end

  // Row of cells; the left edge counts as smaller than any key
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    if (i == 0) begin : g_left_edge
      assign left_l[i] = '{key: '0, state: 1'b0, lt: 1'b1};
    end else begin : g_left
      assign left_l[i] = link[i-1];
    end
    if (i == MAX_RECORDS - 1) begin : g_right_edge
      assign right_l[i] = '0;
    end else begin : g_right
      assign right_l[i] = link[i+1];
    end

    ssrt_cell #(
      .MAX_RECORDS (MAX_RECORDS),
      .IDX         (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .left_i       (left_l[i]),
      .right_i      (right_l[i]),
      .link_o       (link[i]),
      .hit_o        (hit_vec[i]),
      .pick_o       (pick_vec[i]),
      .pick_key_o   (pick_key[i]),
      .pick_state_o (pick_state_vec[i])
    );
  end

  // At most one cell picks; unpicked cells drive zero
  always_comb begin
    sel_key = '0;
    for (int unsigned i = 0; i < MAX_RECORDS; i++) begin
      sel_key = sel_key | pick_key[i];
    end
  end

  // Status and count
  always_comb begin
    status  = ssrt_pkg::ST_OK;
    count_d = count_q;
    case (op_q)
      ssrt_pkg::OP_ADD: begin
        if (full) status = ssrt_pkg::ST_FULL;
        else if (!any_hit) count_d = count_q + CNT_W'(1);
      end
      ssrt_pkg::OP_DEL: begin
        if (!any_hit) status = ssrt_pkg::ST_ABSENT;
        else count_d = count_q - CNT_W'(1);
      end
      ssrt_pkg::OP_FIND, ssrt_pkg::OP_READ: begin
        if (!any_pick) status = ssrt_pkg::ST_ABSENT;
      end
      default: status = ssrt_pkg::ST_OK;
    endcase
  end

  // Response register
  always_comb begin
    rsp_d.status       = status;
    rsp_d.result_key   = sel_key;
    rsp_d.result_state = |pick_state_vec;
    rsp_d.record_total = ssrt_pkg::TOTAL_W'(count_d);
    rsp_valid_d        = rsp_valid_q;
    if (go) rsp_valid_d = 1'b1;
    else if (rsp_o.ready) rsp_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (go) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      rsp_valid_q <= rsp_valid_d;
      if (go) count_q <= count_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

`ifndef NO_ASSERTIONS
  // Record count never passes the row length
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond table depth");

  // Keys are unique, so a key matches in one cell at most
  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("key matched in more than one cell");

  // A response only appears out of an apply cycle
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(fsm_q == S_APPLY))
    else $error("response without apply cycle");

  // Count moves only in an apply cycle
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == S_IDLE) |=> $stable(count_q))
    else $error("record count changed while idle");
`endif

endmodule

`default_nettype wire

>>> design/ssrt_cell.sv
// One position of the sorted record row: holds a key and state, compares
// them against the command and shifts with its neighbours. Uses ssrt_pkg.
`default_nettype none

module ssrt_cell #(
  parameter int unsigned MAX_RECORDS = ssrt_pkg::MAX_RECORDS_DEF,
  parameter int unsigned IDX         = 0,
  localparam int unsigned CNT_W      = $clog2(MAX_RECORDS + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ssrt_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [CNT_W-1:0]         count_i,
  input  wire ssrt_pkg::cell_link_t     left_i,
  input  wire ssrt_pkg::cell_link_t     right_i,
  output ssrt_pkg::cell_link_t          link_o,
  output logic                          hit_o,
  output logic                          pick_o,
  output logic [ssrt_pkg::KEY_W-1:0]    pick_key_o,
  output logic                          pick_state_o
);

  // Positions reachable by the slot field
  localparam bit SLOT_OK = IDX < (1 << ssrt_pkg::SLOT_W);

  logic [ssrt_pkg::KEY_W-1:0] key_q, key_d;
  logic                       state_q, state_d;
  logic                       hit_q, lt_q, pick_q;
  logic                       occ, key_eq, slot_eq;

  assign occ     = CNT_W'(IDX) < count_i;
  assign key_eq  = key_q == ctrl_i.key;
  assign slot_eq = SLOT_OK && (ssrt_pkg::SLOT_W'(IDX) == ctrl_i.slot);

  // Compare flags, captured as the command beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      lt_q   <= 1'b0;
      pick_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      hit_q  <= occ && key_eq;
      lt_q   <= occ && (key_q < ctrl_i.key);
      pick_q <= occ && ctrl_i.pick_en && (ctrl_i.is_read ? slot_eq : key_eq);
    end
  end

  // Insert shifts up from left, delete pulls from right, update sets state
  always_comb begin
    key_d   = key_q;
    state_d = state_q;
    if (ctrl_i.apply_ins && !lt_q) begin
      if (left_i.lt) begin
        key_d   = ctrl_i.key;
        state_d = ctrl_i.new_state;
      end else begin
        key_d   = left_i.key;
        state_d = left_i.state;
      end
    end
    if (ctrl_i.apply_upd && hit_q) begin
      state_d = ctrl_i.new_state;
    end
    if (ctrl_i.apply_del && !lt_q) begin
      key_d   = right_i.key;
      state_d = right_i.state;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    state_q <= state_d;
  end

  assign link_o.key   = key_q;
  assign link_o.state = state_q;
  assign link_o.lt    = lt_q;

  assign hit_o        = hit_q;
  assign pick_o       = pick_q;
  assign pick_key_o   = pick_q ? key_q : '0;
  assign pick_state_o = pick_q & state_q;

endmodule

`default_nettype wire

>>> dv/sorted_schedule_record_table_tb.sv
// Self-checking testbench for sorted_schedule_record_table: drives command beats,
// predicts each response from its own copy of the schedule and checks it.
// Depends on ssrt_pkg, ssrt_chan_if and the design top level.
`default_nettype none

module sorted_schedule_record_table_tb;
  import ssrt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned N_DIRECTED  = 24;
  localparam int unsigned N_RANDOM    = 730;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ssrt_chan_if #(.T(cmd_t)) cmd_if ();
  ssrt_chan_if #(.T(rsp_t)) rsp_if ();

  sorted_schedule_record_table #(
    .MAX_RECORDS(TABLE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Stimulus and bookkeeping
  cmd_t        pending[$];
  rsp_t        rsp_due[$];
  int          live_keys[$];     // keys the generator believes are stored
  int unsigned n_total;
  int unsigned n_taken    = 0;
  int unsigned n_rsp      = 0;
  int unsigned n_errors   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_left  = 0;
  logic        hold_kick  = 1'b0;
  int unsigned op_seen[4] = '{0, 0, 0, 0};
  int unsigned n_full     = 0;
  int unsigned n_absent   = 0;
  int unsigned peak_total = 0;

  // Predictor copy of the schedule
  logic [KEY_W-1:0] sched_key[TABLE_DEPTH];
  logic             sched_on[TABLE_DEPTH];
  int unsigned      sched_count = 0;

  // Apply one command to the schedule copy and return the response it gives
  function automatic rsp_t schedule_apply(input cmd_t c);
    rsp_t r;
    int   pos;
    int   at;
    r = '0;
    r.status = ST_OK;
    pos = -1;
    for (int i = 0; i < int'(sched_count); i++)
      if (pos < 0 && sched_key[i] == c.minute_key) pos = i;
    case (op_e'(c.operation))
      OP_ADD: begin
        if (sched_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (pos >= 0) begin
          sched_on[pos] = c.on_state;
        end else begin
          at = 0;
          while (at < int'(sched_count) && !(c.minute_key < sched_key[at])) at++;
          for (int i = int'(sched_count); i > at; i--) begin
            sched_key[i] = sched_key[i-1];
            sched_on[i]  = sched_on[i-1];
          end
          sched_key[at] = c.minute_key;
          sched_on[at]  = c.on_state;
          sched_count++;
        end
      end
      OP_DEL: begin
        if (pos < 0) begin
          r.status = ST_ABSENT;
        end else begin
          for (int i = pos; i + 1 < int'(sched_count); i++) begin
            sched_key[i] = sched_key[i+1];
            sched_on[i]  = sched_on[i+1];
          end
          sched_count--;
        end
      end
      OP_FIND: begin
        if (pos < 0) begin
          r.status = ST_ABSENT;
        end else begin
          r.result_key   = sched_key[pos];
          r.result_state = sched_on[pos];
        end
      end
      default: begin
        if (int'(c.slot_index) < int'(sched_count)) begin
          r.result_key   = sched_key[c.slot_index];
          r.result_state = sched_on[c.slot_index];
        end else begin
          r.status = ST_ABSENT;
        end
      end
    endcase
    r.record_total = TOTAL_W'(sched_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("cycle %0d, response %0d: %s is %0d, expected %0d",
             cycle_cnt, n_rsp, what, got, want);
  endtask

  // Generator side: queue a command and track which keys it leaves stored
  function automatic void queue_cmd(input op_e op, input int key, input bit st,
                                    input int slot);
    cmd_t c;
    int   p;
    c.operation  = op;
    c.minute_key = KEY_W'(key);
    c.on_state   = st;
    c.slot_index = SLOT_W'(slot);
    pending.push_back(c);
    p = -1;
    foreach (live_keys[i]) if (live_keys[i] == key) p = i;
    if (op == OP_ADD && p < 0 && live_keys.size() < TABLE_DEPTH) live_keys.push_back(key);
    if (op == OP_DEL && p >= 0) live_keys.delete(p);
  endfunction

  function automatic int fresh_key();
    int  k;
    bit  taken;
    do begin
      k = $urandom_range(0, 2047);
      taken = 1'b0;
      foreach (live_keys[i]) if (live_keys[i] == k) taken = 1'b1;
    end while (taken);
    return k;
  endfunction

  function automatic int live_key();
    if (live_keys.size() == 0) return $urandom_range(0, 2047);
    return live_keys[$urandom_range(0, live_keys.size() - 1)];
  endfunction

  // Command driver: holds a beat until taken, predicts on acceptance
  always @(posedge clk_i) begin : cmd_driver
    cmd_t c;
    rsp_t r;
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      cmd_if.data  <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        r = schedule_apply(cmd_if.data);
        rsp_due.push_back(r);
        op_seen[cmd_if.data.operation]++;
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_ABSENT) n_absent++;
        if (sched_count > peak_total) peak_total = sched_count;
        n_taken++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          c = pending.pop_front();
          cmd_if.valid <= 1'b1;
          cmd_if.data  <= c;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Response monitor: compares each beat with the oldest prediction
  always @(posedge clk_i) begin : rsp_monitor
    rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due.size() == 0) begin
          report_mismatch("unexpected response, status", rsp_if.data.status, -1);
        end else begin
          want = rsp_due.pop_front();
          if (rsp_if.data.status !== want.status)
            report_mismatch("status", rsp_if.data.status, want.status);
          if (rsp_if.data.result_key !== want.result_key)
            report_mismatch("result_key", rsp_if.data.result_key, want.result_key);
          if (rsp_if.data.result_state !== want.result_state)
            report_mismatch("result_state", rsp_if.data.result_state, want.result_state);
          if (rsp_if.data.record_total !== want.record_total)
            report_mismatch("record_total", rsp_if.data.record_total, want.record_total);
        end
        n_rsp++;
      end
      rsp_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_cnt, rsp_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int kind;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    rsp_if.ready = 1'b0;

    // Directed: empty list, one-record delete, ordering, update, extremes
    queue_cmd(OP_READ, 0, 1'b0, 0);
    queue_cmd(OP_READ, 0, 1'b0, 31);
    queue_cmd(OP_DEL, 5, 1'b0, 0);
    queue_cmd(OP_FIND, 0, 1'b0, 0);
    queue_cmd(OP_ADD, 2047, 1'b1, 0);
    queue_cmd(OP_DEL, 2046, 1'b0, 0);
    queue_cmd(OP_FIND, 2047, 1'b0, 0);
    queue_cmd(OP_DEL, 2047, 1'b0, 0);
    queue_cmd(OP_ADD, 1439, 1'b0, 0);
    queue_cmd(OP_ADD, 0, 1'b1, 0);
    queue_cmd(OP_ADD, 720, 1'b1, 0);
    queue_cmd(OP_ADD, 720, 1'b0, 0);
    queue_cmd(OP_FIND, 720, 1'b0, 0);
    queue_cmd(OP_READ, 0, 1'b0, 0);
    queue_cmd(OP_READ, 0, 1'b0, 1);
    queue_cmd(OP_READ, 0, 1'b0, 2);
    queue_cmd(OP_READ, 2047, 1'b1, 3);
    queue_cmd(OP_DEL, 0, 1'b0, 0);
    queue_cmd(OP_DEL, 1439, 1'b0, 0);
    queue_cmd(OP_FIND, 1439, 1'b0, 0);
    queue_cmd(OP_ADD, 2047, 1'b1, 0);
    queue_cmd(OP_ADD, 1, 1'b0, 0);
    queue_cmd(OP_FIND, 1366, 1'b1, 21);
    queue_cmd(OP_READ, 1, 1'b0, 1);

    // Random: fill-to-full and drain sequences, mixed traffic, some noise
    while (pending.size() < N_DIRECTED + N_RANDOM) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        while (live_keys.size() < TABLE_DEPTH)
          queue_cmd(OP_ADD, fresh_key(), $urandom_range(0, 1), $urandom_range(0, 31));
        queue_cmd(OP_ADD, live_key(), $urandom_range(0, 1), 0);
        queue_cmd(OP_ADD, fresh_key(), $urandom_range(0, 1), 0);
        queue_cmd(OP_READ, $urandom_range(0, 2047), 1'b0, 31);
        queue_cmd(OP_READ, 0, 1'b0, $urandom_range(0, 31));
        queue_cmd(OP_FIND, live_key(), 1'b0, 0);
      end else if (kind <= 4) begin
        while (live_keys.size() > 0) begin
          if ($urandom_range(0, 3) == 0) queue_cmd(OP_FIND, live_key(), 1'b0, 0);
          queue_cmd(OP_DEL, live_key(), $urandom_range(0, 1), $urandom_range(0, 31));
        end
        queue_cmd(OP_DEL, $urandom_range(0, 2047), 1'b0, 0);
        queue_cmd(OP_READ, 0, 1'b0, 0);
      end else if (kind <= 8) begin
        repeat (20)
          queue_cmd(op_e'($urandom_range(0, 3)),
                    ($urandom_range(0, 9) < 7) ? live_key() : $urandom_range(0, 2047),
                    $urandom_range(0, 1), $urandom_range(0, 31));
      end else begin
        repeat (5)
          queue_cmd(op_e'($urandom_range(0, 3)), $urandom_range(0, 2047),
                    $urandom_range(0, 1), $urandom_range(0, 31));
      end
    end
    n_total = pending.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Idle and stall phases, keyed to how many beats have been taken
    wait (n_taken >= n_total / 6);
    @(negedge clk_i);
    idle_pct = 62;
    wait (n_taken >= 2 * n_total / 6);
    @(negedge clk_i);
    idle_pct  = 0;
    stall_pct = 62;
    wait (n_taken >= 3 * n_total / 6);
    @(negedge clk_i);
    idle_pct  = 35;
    stall_pct = 35;
    wait (n_taken >= 4 * n_total / 6);
    @(negedge clk_i);
    // Receiver holds off while commands keep coming, so the block backs up
    idle_pct  = 0;
    stall_pct = 0;
    hold_kick = 1'b1;
    @(negedge clk_i);
    hold_kick = 1'b0;
    wait (hold_left == 0);
    @(negedge clk_i);
    wait (n_taken >= 5 * n_total / 6);
    @(negedge clk_i);
    idle_pct  = 20;
    stall_pct = 20;

    wait (pending.size() == 0 && n_taken == n_total);
    wait (rsp_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (rsp_due.size() != 0)
      report_mismatch("responses left outstanding", rsp_due.size(), 0);

    $display("Ran %0d commands (%0d add, %0d delete, %0d find, %0d read), %0d responses.",
             n_taken, op_seen[OP_ADD], op_seen[OP_DEL], op_seen[OP_FIND],
             op_seen[OP_READ], n_rsp);
    $display("Full-list refusals %0d, not-present results %0d, peak records %0d.",
             n_full, n_absent, peak_total);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/ssrt_pkg.sv
design/ssrt_chan_if.sv
design/ssrt_cell.sv
design/sorted_schedule_record_table.sv
dv/sorted_schedule_record_table_tb.sv
